@@ sv/sumt_pkg.sv @@
// Shared types and codes for the set union and membership table.
// Used by sumt_ctrl, sumt_dpath and set_union_membership_table; depends on nothing.

package sumt_pkg;

   typedef logic [2:0] action_type;
   typedef logic [1:0] status_type;

   localparam action_type ACT_CLEAR      = 3'd0;
   localparam action_type ACT_ADD_FIRST  = 3'd1;
   localparam action_type ACT_ADD_SECOND = 3'd2;
   localparam action_type ACT_QUERY      = 3'd3;
   localparam action_type ACT_READ       = 3'd4;

   localparam status_type ST_OK         = 2'd0;
   localparam status_type ST_FULL       = 2'd1;
   localparam status_type ST_PAST_COUNT = 2'd2;
   localparam status_type ST_ORDER      = 2'd3;

   localparam int VALUE_W = 32;
   localparam int INDEX_W = 8;
   localparam int COUNT_W = 9;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic latch;       // capture the request beat, start a new item
      logic scan_step;   // issue the next scan read
      logic read_entry;  // read the entry at the requested index
      logic finish;      // apply the action and load the response register
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_done;   // every entry below the scan limit has been issued
      logic out_free;    // the response register can take a beat this cycle
   } dp_stat_type;

endpackage

@@ sv/sumt_ctrl.sv @@
// Controller for the set union and membership table: sequences one item at a time.
// Depends on sumt_pkg for the action codes and the command and status structs.

module sumt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  sumt_pkg::action_type req_action,
   input  sumt_pkg::dp_stat_type stat,
   output sumt_pkg::dp_cmd_type  cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_READ,
      S_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      req_stall      = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.latch = 1'b1;
               unique case (req_action)
                  sumt_pkg::ACT_ADD_SECOND,
                  sumt_pkg::ACT_QUERY: state_in = S_SCAN;
                  sumt_pkg::ACT_READ:  state_in = S_READ;
                  default:             state_in = S_FINISH;
               endcase
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_done) begin
               state_in = S_FINISH;
            end
         end
         S_READ: begin
            cmd.read_entry = 1'b1;
            state_in       = S_FINISH;
         end
         S_FINISH: begin
            cmd.finish = stat.out_free;
            if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ sv/sumt_dpath.sv @@
// Datapath for the set union and membership table: entry memory, counters,
// scan pointer, compare and the response register. Depends on sumt_pkg.

module sumt_dpath #(
   parameter int SET_DEPTH = 128
) (
   input  logic                         clock,
   input  logic                         reset,
   input  sumt_pkg::action_type         req_action,
   input  logic signed [sumt_pkg::VALUE_W-1:0] req_value,
   input  logic [sumt_pkg::INDEX_W-1:0] req_entry_index,
   input  sumt_pkg::dp_cmd_type         cmd,
   output sumt_pkg::dp_stat_type        stat,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output sumt_pkg::status_type         rsp_status,
   output logic                         rsp_found,
   output logic signed [sumt_pkg::VALUE_W-1:0] rsp_entry_value,
   output logic [sumt_pkg::COUNT_W-1:0] rsp_union_count
);

   localparam int STORE_DEPTH = 2 * SET_DEPTH;
   localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
   localparam int FC_W        = $clog2(SET_DEPTH + 1);
   localparam int IDX_W       = (CNT_W > sumt_pkg::INDEX_W) ? CNT_W : sumt_pkg::INDEX_W;

   logic [sumt_pkg::VALUE_W-1:0] store_mem [STORE_DEPTH];

   sumt_pkg::action_type         action_ff;
   logic [sumt_pkg::VALUE_W-1:0] value_ff;
   logic [sumt_pkg::INDEX_W-1:0] index_ff;

   logic [FC_W-1:0]   first_count_ff, first_count_in;
   logic [CNT_W-1:0]  total_count_ff, total_count_in;
   logic              second_ff, second_in;
   logic [CNT_W-1:0]  ptr_ff;
   logic              rd_pend_ff;
   logic              hit_ff;
   logic [sumt_pkg::VALUE_W-1:0] rd_data_ff;

   logic                         rsp_valid_ff;
   sumt_pkg::status_type         status_ff, status_in;
   logic                         found_ff, found_in;
   logic [sumt_pkg::VALUE_W-1:0] entry_ff, entry_in;
   logic [sumt_pkg::COUNT_W-1:0] count_ff;

   logic [CNT_W-1:0]  scan_limit;
   logic              scan_issue;
   logic [IDX_W-1:0]  index_ext;
   logic              index_ok;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic              wr_en;

   // A second-list add only looks at the first-list entries; a query sees them all.
   assign scan_limit = (action_ff == sumt_pkg::ACT_ADD_SECOND) ?
                       CNT_W'(first_count_ff) : total_count_ff;
   assign stat.scan_done = (ptr_ff >= scan_limit);
   assign scan_issue     = cmd.scan_step && !stat.scan_done;

   assign index_ext = IDX_W'(index_ff);
   assign index_ok  = (index_ext < IDX_W'(total_count_ff));

   assign rd_en   = scan_issue || (cmd.read_entry && index_ok);
   assign rd_addr = cmd.read_entry ? index_ext[ADDR_W-1:0] : ptr_ff[ADDR_W-1:0];

   assign stat.out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      first_count_in = first_count_ff;
      total_count_in = total_count_ff;
      second_in      = second_ff;
      status_in      = sumt_pkg::ST_OK;
      found_in       = 1'b0;
      entry_in       = '0;
      wr_en          = 1'b0;
      unique case (action_ff)
         sumt_pkg::ACT_CLEAR: begin
            first_count_in = '0;
            total_count_in = '0;
            second_in      = 1'b0;
         end
         sumt_pkg::ACT_ADD_FIRST: begin
            if (second_ff) begin
               status_in = sumt_pkg::ST_ORDER;
            end else if (first_count_ff >= FC_W'(SET_DEPTH) ||
                         total_count_ff >= CNT_W'(STORE_DEPTH)) begin
               status_in = sumt_pkg::ST_FULL;
            end else begin
               wr_en          = 1'b1;
               first_count_in = first_count_ff + FC_W'(1);
               total_count_in = total_count_ff + CNT_W'(1);
            end
         end
         sumt_pkg::ACT_ADD_SECOND: begin
            second_in = 1'b1;
            if (hit_ff) begin
               found_in = 1'b1;
            end else if (total_count_ff >= CNT_W'(STORE_DEPTH)) begin
               status_in = sumt_pkg::ST_FULL;
            end else begin
               wr_en          = 1'b1;
               total_count_in = total_count_ff + CNT_W'(1);
            end
         end
         sumt_pkg::ACT_QUERY: begin
            found_in = hit_ff;
         end
         sumt_pkg::ACT_READ: begin
            if (index_ok) begin
               entry_in = rd_data_ff;
            end else begin
               status_in = sumt_pkg::ST_PAST_COUNT;
            end
         end
         default: begin
         end
      endcase
   end

   // Entry memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (cmd.finish && wr_en) begin
         store_mem[total_count_ff[ADDR_W-1:0]] <= value_ff;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         action_ff <= req_action;
         value_ff  <= req_value;
         index_ff  <= req_entry_index;
      end
      if (cmd.finish) begin
         status_ff <= status_in;
         found_ff  <= found_in;
         entry_ff  <= entry_in;
         count_ff  <= sumt_pkg::COUNT_W'(total_count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_count_ff <= '0;
         total_count_ff <= '0;
         second_ff      <= 1'b0;
         ptr_ff         <= '0;
         rd_pend_ff     <= 1'b0;
         hit_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rd_pend_ff <= scan_issue;
         if (cmd.latch) begin
            ptr_ff <= '0;
            hit_ff <= 1'b0;
         end else begin
            if (scan_issue) begin
               ptr_ff <= ptr_ff + CNT_W'(1);
            end
            // The compare happens in the cycle after the read is issued.
            if (rd_pend_ff && rd_data_ff == value_ff) begin
               hit_ff <= 1'b1;
            end
         end
         if (cmd.finish) begin
            first_count_ff <= first_count_in;
            total_count_ff <= total_count_in;
            second_ff      <= second_in;
            rsp_valid_ff   <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_found       = found_ff;
   assign rsp_entry_value = entry_ff;
   assign rsp_union_count = count_ff;

endmodule

@@ sv/set_union_membership_table.sv @@
// Top level of the set union and membership table.
// Instantiates sumt_ctrl and sumt_dpath; depends on sumt_pkg.
//
//   Channel   Direction   Handshake               Beat contents
//   req       in          req_valid / req_stall   action, value, entry_index
//   rsp       out         rsp_valid / rsp_stall   status, found, entry_value, union_count
//
// One item is in flight at a time. After the accepting edge, clear, first-list adds and unused
// codes go straight to the finish state, a read first reads the entry, and a second-list add or
// a query first scans N entries, where N is the first-list count or the total count: the entry
// memory's single read port allows one compare per cycle. The response register loads in the
// finish state, and the next beat can be accepted in the same cycle that the response appears.
// Reset is synchronous and empties the table; entry contents are not cleared.
// A held response does not block acceptance of the next request beat, but that item then waits
// in its last cycle until the held beat leaves.

module set_union_membership_table #(
   parameter int SET_DEPTH = 128
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [2:0]                          req_action,
   input  logic signed [sumt_pkg::VALUE_W-1:0] req_value,
   input  logic [sumt_pkg::INDEX_W-1:0]        req_entry_index,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_status,
   output logic                                rsp_found,
   output logic signed [sumt_pkg::VALUE_W-1:0] rsp_entry_value,
   output logic [sumt_pkg::COUNT_W-1:0]        rsp_union_count
);

   sumt_pkg::dp_cmd_type  cmd;
   sumt_pkg::dp_stat_type stat;

   sumt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_action (req_action),
      .stat       (stat),
      .cmd        (cmd)
   );

   sumt_dpath #(
      .SET_DEPTH (SET_DEPTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_action      (req_action),
      .req_value       (req_value),
      .req_entry_index (req_entry_index),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_found       (rsp_found),
      .rsp_entry_value (rsp_entry_value),
      .rsp_union_count (rsp_union_count)
   );

endmodule
